/* sv/pll_divider_search_encode_core_defines.svh */
// assertion macros for the divider search block
`ifndef PLL_DIVIDER_SEARCH_ENCODE_CORE_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_ENCODE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLLDSE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plldse same-cycle check failed");
`define PLLDSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plldse next-cycle check failed");
`else
`define PLLDSE_ASSERT_SAME(lbl, ante, cons)
`define PLLDSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/plldse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plldse_pkg;

  localparam int MULT_SEARCH_MAX   = 60;
  localparam int PREDIV_SEARCH_END = 256;
  localparam int MULT_LFSR_MAX     = 32768;
  localparam int PREDIV_LFSR_MAX   = 256;

  localparam int REF_W    = 26;
  localparam int VCO_W    = 30;
  localparam int TARGET_W = 29;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 30;

  localparam int MW   = $clog2(MULT_SEARCH_MAX + 1);
  localparam int NW   = $clog2(PREDIV_SEARCH_END);
  localparam int PW   = REF_W + 1 + MW;
  localparam int MCW  = $clog2(MULT_LFSR_MAX + 2);
  localparam int NCW  = $clog2(PREDIV_LFSR_MAX + 2);

  localparam int MULT_VAL_W   = 6;
  localparam int PREDIV_VAL_W = 8;
  localparam int MULT_CODE_W  = 17;
  localparam int PREDIV_CODE_W = 10;
  localparam int INT_GAIN_W   = 7;
  localparam int PROP_GAIN_W  = 5;
  localparam int MULT_LFSR_W  = 15;
  localparam int PREDIV_LFSR_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX   = 2'd2;

  localparam logic [REF_W-1:0] REF_CLOCK_RST = 26'd12000000;
  localparam logic [VCO_W-1:0] VCO_MIN_RST   = 30'd60000000;
  localparam logic [VCO_W-1:0] VCO_MAX_RST   = 30'd500000000;

  localparam logic [MULT_CODE_W-1:0]   MULT_CODE_M1   = 17'h18003;
  localparam logic [MULT_CODE_W-1:0]   MULT_CODE_M2   = 17'h10003;
  localparam logic [MULT_LFSR_W-1:0]   MULT_SEED      = 15'h4000;
  localparam logic [PREDIV_CODE_W-1:0] PREDIV_CODE_N1 = 10'h302;
  localparam logic [PREDIV_CODE_W-1:0] PREDIV_CODE_N2 = 10'h202;
  localparam logic [PREDIV_LFSR_W-1:0] PREDIV_SEED    = 8'h80;
  localparam logic [MULT_VAL_W-1:0]    GAIN_MASK      = 6'h3c;
  localparam logic [INT_GAIN_W-1:0]    INT_GAIN_OFS   = 7'd4;
  localparam logic [PROP_GAIN_W-1:0]   PROP_GAIN_OFS  = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV,
    ST_CHECK,
    ST_ENCODE,
    ST_FINISH
  } plldse_state_t;

endpackage

`default_nettype wire

/* sv/pll_divider_search_encode_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall  | in_target_hz
// out     | out of    | out_valid / out_stall| out_found .. out_prop_gain_sel
// cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// each (m, n) trial runs launch, a wait on the divider, then check
// a full miss takes 60 * 255 trials; on a hit, for m or n above 2, the lfsrs are
// stepped to form the codes before the result is loaded
// one item at a time; in_stall is low only while idle, even if a result still waits
// register writes are taken only while idle and no item is offered
// rst_n is synchronous; registers return to 12 MHz, 60 MHz and 500 MHz

module pll_divider_search_encode_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [plldse_pkg::TARGET_W-1:0]       in_target_hz,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_found,
  output logic [plldse_pkg::MULT_VAL_W-1:0]          out_mult_value,
  output logic [plldse_pkg::PREDIV_VAL_W-1:0]        out_prediv_value,
  output logic [plldse_pkg::MULT_CODE_W-1:0]         out_mult_code,
  output logic [plldse_pkg::PREDIV_CODE_W-1:0]       out_prediv_code,
  output logic [plldse_pkg::INT_GAIN_W-1:0]          out_int_gain_sel,
  output logic [plldse_pkg::PROP_GAIN_W-1:0]         out_prop_gain_sel,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [plldse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [plldse_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import plldse_pkg::*;

  `include "pll_divider_search_encode_core_defines.svh"

  plldse_state_t state_r, state_nxt;

  logic [REF_W-1:0]    ref_r;
  logic [VCO_W-1:0]    vmin_r;
  logic [VCO_W-1:0]    vmax_r;
  logic [TARGET_W-1:0] target_r;
  logic [MW-1:0]       m_r;
  logic [NW-1:0]       n_r;
  logic [PW-1:0]       prod_r;
  logic                found_r;
  logic [MCW-1:0]      mcnt_r;
  logic [NCW-1:0]      ncnt_r;
  logic [MULT_LFSR_W-1:0]   mx_r;
  logic [PREDIV_LFSR_W-1:0] nx_r;

  logic                out_valid_r;
  logic                out_found_r;
  logic [MULT_VAL_W-1:0]    out_m_r;
  logic [PREDIV_VAL_W-1:0]  out_n_r;
  logic [MULT_CODE_W-1:0]   out_mcode_r;
  logic [PREDIV_CODE_W-1:0] out_ncode_r;
  logic [INT_GAIN_W-1:0]    out_igain_r;
  logic [PROP_GAIN_W-1:0]   out_pgain_r;

  logic          div_start;
  logic          div_done;
  logic [PW-1:0] div_quotient;
  logic [PW-1:0] twice_ref;
  logic          hit;
  logic          n_last;
  logic          m_last;
  logic          enc_done;
  logic          out_free;
  logic          out_load;
  logic          in_take;

  logic [MULT_CODE_W-1:0]   mcode_sel;
  logic [PREDIV_CODE_W-1:0] ncode_sel;

  plldse_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .div_start    (div_start),
    .div_dividend (prod_r),
    .div_divisor  (n_r),
    .div_done     (div_done),
    .div_quotient (div_quotient)
  );

  assign twice_ref = {{(PW-REF_W-1){1'b0}}, ref_r, 1'b0};
  assign hit = (div_quotient[PW-1:1] == {{(PW-1-TARGET_W){1'b0}}, target_r})
            && (div_quotient >= {{(PW-VCO_W){1'b0}}, vmin_r})
            && (div_quotient <= {{(PW-VCO_W){1'b0}}, vmax_r});
  assign n_last   = (n_r == NW'(PREDIV_SEARCH_END - 1));
  assign m_last   = (m_r == MW'(MULT_SEARCH_MAX));
  assign enc_done = (mcnt_r == '0) && (ncnt_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (hit) state_nxt = ST_ENCODE;
        else if (n_last && m_last) state_nxt = ST_FINISH;
        else state_nxt = ST_LAUNCH;
      end
      ST_ENCODE: if (enc_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = !in_valid;
      end
      ST_LAUNCH: div_start = 1'b1;
      ST_FINISH: out_load  = out_free;
      ST_DIV, ST_CHECK, ST_ENCODE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= REF_CLOCK_RST;
      vmin_r <= VCO_MIN_RST;
      vmax_r <= VCO_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REF_CLOCK: ref_r  <= cfg_data[REF_W-1:0];
        REG_VCO_MIN:   vmin_r <= cfg_data[VCO_W-1:0];
        REG_VCO_MAX:   vmax_r <= cfg_data[VCO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // search and encode datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      mcnt_r  <= '0;
      ncnt_r  <= '0;
    end else if (in_take) begin
      target_r <= in_target_hz;
      m_r      <= MW'(1);
      n_r      <= NW'(1);
      prod_r   <= twice_ref;
      found_r  <= 1'b0;
    end else if (state_r == ST_CHECK) begin
      if (hit) begin
        found_r <= 1'b1;
        mx_r    <= MULT_SEED;
        nx_r    <= PREDIV_SEED;
        mcnt_r  <= (m_r > MW'(2)) ? (MCW'(MULT_LFSR_MAX + 1) - MCW'(m_r)) : '0;
        ncnt_r  <= (n_r > NW'(2)) ? (NCW'(PREDIV_LFSR_MAX + 1) - NCW'(n_r)) : '0;
      end else if (n_last) begin
        if (!m_last) begin
          m_r    <= m_r + MW'(1);
          n_r    <= NW'(1);
          prod_r <= prod_r + twice_ref;
        end
      end else begin
        n_r <= n_r + NW'(1);
      end
    end else if (state_r == ST_ENCODE) begin
      if (mcnt_r != '0) begin
        mx_r   <= {mx_r[0] ^ mx_r[1], mx_r[MULT_LFSR_W-1:1]};
        mcnt_r <= mcnt_r - MCW'(1);
      end
      if (ncnt_r != '0) begin
        nx_r   <= {nx_r[0] ^ nx_r[2] ^ nx_r[3] ^ nx_r[4], nx_r[PREDIV_LFSR_W-1:1]};
        ncnt_r <= ncnt_r - NCW'(1);
      end
    end
  end

  always_comb begin
    case (m_r)
      MW'(1):  mcode_sel = MULT_CODE_M1;
      MW'(2):  mcode_sel = MULT_CODE_M2;
      default: mcode_sel = {{(MULT_CODE_W-MULT_LFSR_W){1'b0}}, mx_r};
    endcase
    case (n_r)
      NW'(1):  ncode_sel = PREDIV_CODE_N1;
      NW'(2):  ncode_sel = PREDIV_CODE_N2;
      default: ncode_sel = {{(PREDIV_CODE_W-PREDIV_LFSR_W){1'b0}}, nx_r};
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found_r;
      if (found_r) begin
        out_m_r     <= MULT_VAL_W'(m_r);
        out_n_r     <= PREDIV_VAL_W'(n_r);
        out_mcode_r <= mcode_sel;
        out_ncode_r <= ncode_sel;
        out_igain_r <= INT_GAIN_W'(MULT_VAL_W'(m_r) & GAIN_MASK) + INT_GAIN_OFS;
        out_pgain_r <= PROP_GAIN_W'(m_r >> 1) + PROP_GAIN_OFS;
      end else begin
        out_m_r     <= '0;
        out_n_r     <= '0;
        out_mcode_r <= '0;
        out_ncode_r <= '0;
        out_igain_r <= '0;
        out_pgain_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_mult_value    = out_m_r;
  assign out_prediv_value  = out_n_r;
  assign out_mult_code     = out_mcode_r;
  assign out_prediv_code   = out_ncode_r;
  assign out_int_gain_sel  = out_igain_r;
  assign out_prop_gain_sel = out_pgain_r;

  `PLLDSE_ASSERT_SAME(a_done_only_in_div, div_done, state_r == ST_DIV)
  `PLLDSE_ASSERT_NEXT(a_encode_ends, (state_r == ST_ENCODE) && enc_done, state_r == ST_FINISH)
  `PLLDSE_ASSERT_SAME(a_found_nonzero, out_valid_r && out_found_r, (out_m_r != '0) && (out_n_r != '0))
  `PLLDSE_ASSERT_SAME(a_miss_zero, out_valid_r && !out_found_r, (out_mcode_r == '0) && (out_ncode_r == '0))

endmodule

`default_nettype wire

/* sv/plldse_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module plldse_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    div_start,
  input  wire logic [plldse_pkg::PW-1:0] div_dividend,
  input  wire logic [plldse_pkg::NW-1:0] div_divisor,
  output logic                         div_done,
  output logic [plldse_pkg::PW-1:0]    div_quotient
);
  import plldse_pkg::*;

  localparam int CW = $clog2(PW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] dsr_r;
  logic [PW-1:0] quo_r;
  logic [NW:0]   trial;
  logic          take;
  logic [NW:0]   diff;

  assign trial = {rem_r, quo_r[PW-1]};
  assign take  = (trial >= {1'b0, dsr_r});
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (div_start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(PW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      rem_r <= '0;
      dsr_r <= div_divisor;
      quo_r <= div_dividend;
    end else if (busy_r) begin
      rem_r <= take ? diff[NW-1:0] : trial[NW-1:0];
      quo_r <= {quo_r[PW-2:0], take};
    end
  end

  assign div_done     = done_r;
  assign div_quotient = quo_r;

endmodule

`default_nettype wire
